@@ sv/wlrs_pkg.sv @@
// Package for the wear-levelled record store.
// Holds command and status codes, field widths and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wlrs_pkg;

	localparam int CMD_W   = 2;
	localparam int KEY_W   = 8;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 8;
	localparam int PROT_LIMIT = 255;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_PROT     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOFREE   = 2'd3;

	// Register index of protection_enable (paddr[2]).
	localparam logic REG_PROT_IDX = 1'b0;

	typedef struct packed {
		logic load_item;
		logic scan_init;
		logic scan_free;
		logic scan_run;
		logic cap_old;
		logic cap_new;
		logic cap_val;
		logic wr_new;
		logic clr_old;
		logic clr_step;
		logic inc_count;
	} wlrs_cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic clear_last;
		logic limit;
	} wlrs_stat_t;

endpackage

`default_nettype wire

@@ sv/wlrs_ctrl.sv @@
// Controller state machine of the wear-levelled record store.
// Depends on wlrs_pkg; drives the datapath through wlrs_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module wlrs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wlrs_pkg::CMD_W-1:0]    command,
	input  wire wlrs_pkg::wlrs_stat_t          stat,
	output wlrs_pkg::wlrs_cmd_t                cmd,
	output logic                               busy,
	output logic                               done,
	output logic [wlrs_pkg::STAT_W-1:0]        status
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_KSCAN  = 3'd2;
	localparam logic [2:0] S_FSCAN  = 3'd3;
	localparam logic [2:0] S_WRNEW  = 3'd4;
	localparam logic [2:0] S_CLROLD = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]                      state_q, state_d;
	logic [wlrs_pkg::CMD_W-1:0]      cmd_q, cmd_d;
	logic [wlrs_pkg::STAT_W-1:0]     status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cmd_q    <= wlrs_pkg::CMD_WRITE;
			status_q <= wlrs_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			cmd_q    <= cmd_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cmd_d    = cmd_q;
		status_d = status_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					cmd_d         = command;
					status_d      = wlrs_pkg::ST_OK;
					case (command)
						wlrs_pkg::CMD_WRITE: begin
							if (stat.limit) begin
								status_d = wlrs_pkg::ST_PROT;
								state_d  = S_DONE;
							end else begin
								cmd.scan_init = 1'b1;
								cmd.scan_free = 1'b1;
								state_d       = S_FSCAN;
							end
						end
						wlrs_pkg::CMD_UPDATE: begin
							if (stat.limit) begin
								status_d = wlrs_pkg::ST_PROT;
								state_d  = S_DONE;
							end else begin
								cmd.scan_init = 1'b1;
								state_d       = S_KSCAN;
							end
						end
						wlrs_pkg::CMD_LOOKUP: begin
							cmd.scan_init = 1'b1;
							state_d       = S_KSCAN;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_KSCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					cmd.cap_old = 1'b1;
					if (cmd_q == wlrs_pkg::CMD_LOOKUP) begin
						cmd.cap_val = 1'b1;
						state_d     = S_DONE;
					end else begin
						// The old record stays valid, so the free search skips it.
						cmd.scan_init = 1'b1;
						cmd.scan_free = 1'b1;
						state_d       = S_FSCAN;
					end
				end else if (stat.miss) begin
					status_d = wlrs_pkg::ST_NOTFOUND;
					state_d  = S_DONE;
				end
			end
			S_FSCAN: begin
				cmd.scan_run  = 1'b1;
				cmd.scan_free = 1'b1;
				if (stat.hit) begin
					cmd.cap_new = 1'b1;
					state_d     = S_WRNEW;
				end else if (stat.miss) begin
					status_d = wlrs_pkg::ST_NOFREE;
					state_d  = S_DONE;
				end
			end
			S_WRNEW: begin
				cmd.wr_new    = 1'b1;
				cmd.inc_count = 1'b1;
				state_d = (cmd_q == wlrs_pkg::CMD_UPDATE) ? S_CLROLD : S_DONE;
			end
			S_CLROLD: begin
				cmd.clr_old = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign status = status_q;

endmodule

`default_nettype wire

@@ sv/wlrs_datapath.sv @@
// Datapath of the wear-levelled record store: slot memories, scan unit,
// search pointer and protection counter. Depends on wlrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wlrs_datapath #(
	parameter int SLOTS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wlrs_pkg::wlrs_cmd_t           cmd,
	output wlrs_pkg::wlrs_stat_t               stat,
	input  wire logic                          prot_en,
	input  wire logic [wlrs_pkg::KEY_W-1:0]    key,
	input  wire logic [wlrs_pkg::VAL_W-1:0]    value,
	output logic [wlrs_pkg::SLOT_W-1:0]        written_slot,
	output logic [wlrs_pkg::SLOT_W-1:0]        found_slot,
	output logic [wlrs_pkg::VAL_W-1:0]         read_value
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int VKW = wlrs_pkg::KEY_W + 1;

	// Slot memories: valid bit with key, and data. Read data is registered.
	logic [VKW-1:0]              vk_mem [SLOTS];
	logic [wlrs_pkg::VAL_W-1:0]  data_mem [SLOTS];
	logic [VKW-1:0]              vk_rd_s1;
	logic [wlrs_pkg::VAL_W-1:0]  data_rd_s1;

	logic [AW-1:0]               issue_idx_q;
	logic [CW-1:0]               issued_q;
	logic                        pend_s1;
	logic [AW-1:0]               idx_s1;
	logic                        free_q;
	logic [AW-1:0]               clr_idx_q;
	logic [AW-1:0]               ptr_q;
	logic [wlrs_pkg::COUNT_W-1:0] count_q;

	logic [wlrs_pkg::KEY_W-1:0]  key_q;
	logic [wlrs_pkg::VAL_W-1:0]  val_in_q;
	logic [AW-1:0]               old_q;
	logic [AW-1:0]               new_q;
	logic [wlrs_pkg::VAL_W-1:0]  rval_q;

	logic                        vk_we;
	logic [AW-1:0]               vk_waddr;
	logic [VKW-1:0]              vk_wdata;
	logic                        can_issue;

	assign can_issue = (issued_q < CW'(SLOTS));

	always_comb begin
		vk_we    = 1'b0;
		vk_waddr = clr_idx_q;
		vk_wdata = '0;
		if (cmd.clr_step) begin
			vk_we = 1'b1;
		end else if (cmd.wr_new) begin
			vk_we    = 1'b1;
			vk_waddr = new_q;
			vk_wdata = {1'b1, key_q};
		end else if (cmd.clr_old) begin
			vk_we    = 1'b1;
			vk_waddr = old_q;
			vk_wdata = {1'b0, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (vk_we) begin
			vk_mem[vk_waddr] <= vk_wdata;
		end
		vk_rd_s1 <= vk_mem[issue_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			data_mem[new_q] <= val_in_q;
		end
		data_rd_s1 <= data_mem[issue_idx_q];
	end

	// Scan unit: one slot read issued per cycle, compared when its data returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_idx_q <= '0;
			issued_q    <= '0;
			pend_s1     <= 1'b0;
			free_q      <= 1'b0;
		end else if (cmd.scan_init) begin
			issue_idx_q <= cmd.scan_free ? ptr_q : '0;
			issued_q    <= '0;
			pend_s1     <= 1'b0;
			free_q      <= cmd.scan_free;
		end else if (cmd.scan_run) begin
			pend_s1 <= can_issue;
			if (can_issue) begin
				issued_q <= issued_q + CW'(1);
				if (issue_idx_q == AW'(SLOTS - 1)) begin
					issue_idx_q <= '0;
				end else begin
					issue_idx_q <= issue_idx_q + AW'(1);
				end
			end
		end else begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			ptr_q     <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (cmd.wr_new) begin
				ptr_q <= new_q;
			end
			if (cmd.inc_count && prot_en) begin
				count_q <= count_q + wlrs_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q    <= key;
			val_in_q <= value;
			old_q    <= '0;
			new_q    <= '0;
			rval_q   <= '0;
		end else begin
			if (cmd.cap_old) begin
				old_q <= idx_s1;
			end
			if (cmd.cap_new) begin
				new_q <= idx_s1;
			end
			if (cmd.cap_val) begin
				rval_q <= data_rd_s1;
			end
		end
	end

	always_comb begin
		stat.hit = pend_s1 && (free_q ? !vk_rd_s1[VKW-1]
			: (vk_rd_s1[VKW-1] && (vk_rd_s1[wlrs_pkg::KEY_W-1:0] == key_q)));
		stat.miss = !pend_s1 && !can_issue;
		stat.clear_last = (clr_idx_q == AW'(SLOTS - 1));
		stat.limit = prot_en
			&& (({1'b0, count_q} + 9'd1) >= 9'(wlrs_pkg::PROT_LIMIT));
	end

	assign written_slot = wlrs_pkg::SLOT_W'(new_q);
	assign found_slot   = wlrs_pkg::SLOT_W'(old_q);
	assign read_value   = rval_q;

endmodule

`default_nettype wire

@@ sv/wear_leveled_record_store.sv @@
// Top level of the wear-levelled record store: configuration register,
// controller and datapath. Depends on wlrs_pkg, wlrs_ctrl and wlrs_datapath.
//
//   channel   handshake                        payload
//   item in   start, accepted when busy low    command, key, value
//   result    done, one cycle, always taken    status, written_slot, found_slot, read_value
//   config    APB write, pready tied high      pwdata (protection_enable at address 0)
//
// After reset a clearing pass marks every slot free; busy stays high while it runs.
// Each search reads one slot a cycle from the slot memory, so the slot memory read port
// sets the time of a write, a lookup or an update; an update runs a key search and then
// a free search, and a limit hit or an unused command runs no search.
// One item is handled at a time; busy stays high until its result has been shown.
// The result stays on the ports from the cycle in which done is high until the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none

module wear_leveled_record_store #(
	parameter int SLOTS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [wlrs_pkg::CMD_W-1:0]    command,
	input  wire logic [wlrs_pkg::KEY_W-1:0]    key,
	input  wire logic [wlrs_pkg::VAL_W-1:0]    value,
	output logic                               done,
	output logic [wlrs_pkg::STAT_W-1:0]        status,
	output logic [wlrs_pkg::SLOT_W-1:0]        written_slot,
	output logic [wlrs_pkg::SLOT_W-1:0]        found_slot,
	output logic [wlrs_pkg::VAL_W-1:0]         read_value,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic                  prot_en_q;
	wlrs_pkg::wlrs_cmd_t   cmd;
	wlrs_pkg::wlrs_stat_t  stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prot_en_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == wlrs_pkg::REG_PROT_IDX)) begin
			prot_en_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == wlrs_pkg::REG_PROT_IDX) ? {31'd0, prot_en_q} : 32'd0;

	wlrs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.status  (status)
	);

	wlrs_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.prot_en      (prot_en_q),
		.key          (key),
		.value        (value),
		.written_slot (written_slot),
		.found_slot   (found_slot),
		.read_value   (read_value)
	);

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while not busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_prot_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == wlrs_pkg::ST_PROT) |->
			(written_slot == '0) && (found_slot == '0) && (read_value == '0))
		else $error("protection result carries slot or value");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for wear_leveled_record_store: a queue-fed command driver,
// a result monitor with an inline slot-store predictor, and APB configuration writes.
// Depends on wlrs_pkg and the wear_leveled_record_store RTL.
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS = 64;
	localparam int POOL = 24;
	localparam int LIMIT = 600000;
	localparam logic [wlrs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] PROT_ADDR = 3'd0;

	typedef struct packed {
		logic [wlrs_pkg::CMD_W-1:0] cmd;
		logic [wlrs_pkg::KEY_W-1:0] key;
		logic [wlrs_pkg::VAL_W-1:0] value;
	} record_op_t;

	typedef struct packed {
		logic [wlrs_pkg::STAT_W-1:0] status;
		logic [wlrs_pkg::SLOT_W-1:0] written_slot;
		logic [wlrs_pkg::SLOT_W-1:0] found_slot;
		logic [wlrs_pkg::VAL_W-1:0] read_value;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [wlrs_pkg::CMD_W-1:0] command = '0;
	logic [wlrs_pkg::KEY_W-1:0] key = '0;
	logic [wlrs_pkg::VAL_W-1:0] value = '0;
	logic done;
	logic [wlrs_pkg::STAT_W-1:0] status;
	logic [wlrs_pkg::SLOT_W-1:0] written_slot;
	logic [wlrs_pkg::SLOT_W-1:0] found_slot;
	logic [wlrs_pkg::VAL_W-1:0] read_value;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Shadow of the slot store.
	bit slot_used [SLOTS];
	logic [wlrs_pkg::KEY_W-1:0] slot_tag [SLOTS];
	logic [wlrs_pkg::VAL_W-1:0] slot_word [SLOTS];
	int next_ptr = 0;
	logic [wlrs_pkg::COUNT_W-1:0] wear_count = '0;
	bit prot_on = 1'b0;

	record_op_t pending_ops [$];
	outcome_t expected_outcomes [$];
	logic [wlrs_pkg::KEY_W-1:0] key_pool [POOL];
	bit took_item = 1'b0;
	bit calm = 1'b0;
	bit go;
	int writes_left;
	int fault_count = 0;
	int cycle_count = 0;
	outcome_t want;

	wear_leveled_record_store #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .key(key), .value(value),
		.done(done), .status(status), .written_slot(written_slot),
		.found_slot(found_slot), .read_value(read_value),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit at_limit();
		return prot_on && (int'(wear_count) + 1 >= wlrs_pkg::PROT_LIMIT);
	endfunction

	function automatic bit find_key(logic [wlrs_pkg::KEY_W-1:0] k,
			output logic [wlrs_pkg::SLOT_W-1:0] slot);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && slot_tag[i] == k) begin
				slot = wlrs_pkg::SLOT_W'(i);
				return 1'b1;
			end
		end
		slot = '0;
		return 1'b0;
	endfunction

	// Circular search from the pointer; the pointer only moves on success.
	function automatic bit find_free(output logic [wlrs_pkg::SLOT_W-1:0] slot);
		int i;
		for (int j = 0; j < SLOTS; j++) begin
			i = (next_ptr + j) % SLOTS;
			if (!slot_used[i]) begin
				next_ptr = i;
				slot = wlrs_pkg::SLOT_W'(i);
				return 1'b1;
			end
		end
		slot = '0;
		return 1'b0;
	endfunction

	function automatic void store_record(logic [wlrs_pkg::SLOT_W-1:0] s,
			logic [wlrs_pkg::KEY_W-1:0] k, logic [wlrs_pkg::VAL_W-1:0] v);
		slot_used[s] = 1'b1;
		slot_tag[s] = k;
		slot_word[s] = v;
		if (prot_on)
			wear_count = wear_count + wlrs_pkg::COUNT_W'(1);
	endfunction

	function automatic outcome_t apply_record_op(logic [wlrs_pkg::CMD_W-1:0] c,
			logic [wlrs_pkg::KEY_W-1:0] k, logic [wlrs_pkg::VAL_W-1:0] v);
		outcome_t r;
		logic [wlrs_pkg::SLOT_W-1:0] old_slot;
		logic [wlrs_pkg::SLOT_W-1:0] new_slot;
		r = '0;
		case (c)
			wlrs_pkg::CMD_WRITE: begin
				if (at_limit())
					r.status = wlrs_pkg::ST_PROT;
				else if (!find_free(new_slot))
					r.status = wlrs_pkg::ST_NOFREE;
				else begin
					store_record(new_slot, k, v);
					r.written_slot = new_slot;
				end
			end
			wlrs_pkg::CMD_UPDATE: begin
				if (at_limit())
					r.status = wlrs_pkg::ST_PROT;
				else if (!find_key(k, old_slot))
					r.status = wlrs_pkg::ST_NOTFOUND;
				else begin
					r.found_slot = old_slot;
					// The old record is still marked used while the free slot is sought.
					if (!find_free(new_slot))
						r.status = wlrs_pkg::ST_NOFREE;
					else begin
						slot_used[old_slot] = 1'b0;
						store_record(new_slot, k, v);
						r.written_slot = new_slot;
					end
				end
			end
			wlrs_pkg::CMD_LOOKUP: begin
				if (find_key(k, old_slot)) begin
					r.found_slot = old_slot;
					r.read_value = slot_word[old_slot];
				end else
					r.status = wlrs_pkg::ST_NOTFOUND;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Driver: takes the head of the queue off once it has been accepted.
	always @(negedge clk) begin
		if (took_item) begin
			void'(pending_ops.pop_front());
			took_item = 1'b0;
		end
		go = 1'b0;
		if (arst_n && pending_ops.size() > 0)
			go = calm || ($urandom_range(0, 99) >= 29);
		start <= go;
		if (go) begin
			command <= pending_ops[0].cmd;
			key <= pending_ops[0].key;
			value <= pending_ops[0].value;
		end
	end

	// Monitor: predicts on acceptance and checks each result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result with no item outstanding: status %0d", status);
				fault_count++;
			end else begin
				want = expected_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fault_count++;
				end
				if (written_slot !== want.written_slot) begin
					$error("written_slot: expected %0d, got %0d", want.written_slot,
						written_slot);
					fault_count++;
				end
				if (found_slot !== want.found_slot) begin
					$error("found_slot: expected %0d, got %0d", want.found_slot, found_slot);
					fault_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0h, got %0h", want.read_value, read_value);
					fault_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			expected_outcomes.push_back(apply_record_op(command, key, value));
			took_item = 1'b1;
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[wear_leveled_record_store] ERROR");
		$finish;
	end

	task automatic settle();
		@(posedge clk);
		while (pending_ops.size() != 0 || start || expected_outcomes.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the enable bit with random upper data bits, then reads it back.
	task automatic set_protection(bit en);
		logic [31:0] rnd;
		rnd = $urandom;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PROT_ADDR;
		pwdata <= {rnd[31:1], en};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		prot_on = en;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== en) begin
			$error("protection_enable: expected %0d, got %0d", en, prdata[0]);
			fault_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_op(logic [wlrs_pkg::CMD_W-1:0] c, logic [wlrs_pkg::KEY_W-1:0] k,
			logic [wlrs_pkg::VAL_W-1:0] v);
		pending_ops.push_back('{cmd: c, key: k, value: v});
	endtask

	// Mostly pool keys so that updates and lookups hit; the rest is noise.
	task automatic queue_mix(int n, int wr_pct, int up_pct, int lk_pct);
		int roll;
		logic [wlrs_pkg::CMD_W-1:0] c;
		logic [wlrs_pkg::KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			k = key_pool[$urandom_range(0, POOL - 1)];
			if (roll < wr_pct && writes_left > 0) begin
				c = wlrs_pkg::CMD_WRITE;
				writes_left--;
			end else if (roll < wr_pct + up_pct)
				c = wlrs_pkg::CMD_UPDATE;
			else if (roll < wr_pct + up_pct + lk_pct)
				c = wlrs_pkg::CMD_LOOKUP;
			else begin
				k = wlrs_pkg::KEY_W'($urandom_range(0, 255));
				case ($urandom_range(0, 2))
					0: c = wlrs_pkg::CMD_UPDATE;
					1: c = wlrs_pkg::CMD_LOOKUP;
					default: c = CMD_UNUSED;
				endcase
			end
			push_op(c, k, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < POOL; i++)
			key_pool[i] = wlrs_pkg::KEY_W'($urandom_range(0, 255));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Let the clearing pass after reset finish.
		repeat (2) @(posedge clk);
		settle();
		set_protection(1'b0);

		push_op(wlrs_pkg::CMD_LOOKUP, 8'h00, 32'h0);
		push_op(wlrs_pkg::CMD_UPDATE, 8'hFF, 32'hFFFF_FFFF);
		push_op(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		push_op(wlrs_pkg::CMD_WRITE, 8'h00, 32'h0);
		push_op(wlrs_pkg::CMD_WRITE, 8'hFF, 32'hFFFF_FFFF);
		push_op(wlrs_pkg::CMD_WRITE, 8'hFF, 32'h5A5A_5A5A);
		push_op(wlrs_pkg::CMD_LOOKUP, 8'hFF, 32'h0);
		push_op(wlrs_pkg::CMD_UPDATE, 8'hFF, 32'h1234_5678);
		push_op(wlrs_pkg::CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
		push_op(wlrs_pkg::CMD_WRITE, 8'hA5, 32'hA5A5_A5A5);
		push_op(wlrs_pkg::CMD_UPDATE, 8'h00, 32'hFFFF_FFFF);
		push_op(wlrs_pkg::CMD_LOOKUP, 8'h00, 32'h0);
		push_op(wlrs_pkg::CMD_LOOKUP, 8'h5A, 32'h0);
		push_op(CMD_UNUSED, 8'h00, 32'h0);
		push_op(wlrs_pkg::CMD_UPDATE, 8'hA5, 32'h0);
		push_op(wlrs_pkg::CMD_LOOKUP, 8'hA5, 32'h0);
		settle();

		// Writes are capped so that the store stays well short of full until the fill.
		writes_left = 36;
		set_protection(1'b1);
		queue_mix(260, 15, 55, 25);
		settle();

		// The counter holds its value while protection is off.
		set_protection(1'b0);
		calm = 1'b1;
		queue_mix(100, 10, 50, 30);
		settle();
		calm = 1'b0;

		// Enough successful updates here to run into the protection limit.
		set_protection(1'b1);
		queue_mix(260, 10, 70, 15);
		settle();

		// Fill every slot, then updates and writes find no free slot.
		set_protection(1'b0);
		for (int i = 0; i < SLOTS + 8; i++)
			push_op(wlrs_pkg::CMD_WRITE, wlrs_pkg::KEY_W'($urandom_range(0, 255)), $urandom);
		writes_left = 6;
		queue_mix(60, 10, 45, 35);
		settle();

		set_protection(1'b1);
		writes_left = 5;
		queue_mix(20, 25, 40, 25);
		settle();

		repeat (2 * SLOTS + 10) @(posedge clk);
		if (fault_count == 0)
			$display("[wear_leveled_record_store] OK");
		else
			$display("[wear_leveled_record_store] ERROR");
		$finish;
	end

endmodule
